/* design/positional_array_list_assert.svh */
// Assertion macros for the positional array list.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define PAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pal_pkg.sv */
`default_nettype none

package pal_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic signed [31:0] class_value;
  } rec_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [6:0]         position;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic signed [31:0] class_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         list_length;
    logic [63:0]        read_name_low;
    logic [63:0]        read_name_mid;
    logic [31:0]        read_name_high;
    logic signed [31:0] read_class;
  } resp_t;

endpackage

`default_nettype wire

/* design/positional_array_list.sv */
// Channel  Direction  Payload          Handshake
// req      in         pal_pkg::req_t   req_valid / req_stall
// resp     out        pal_pkg::resp_t  resp_valid / resp_stall
//
// One request at a time; req_stall is high from acceptance until the result is loaded.
// Inserts and deletes shift n entries, a read fetches one entry and a rejected request goes
// straight to S_EMIT; the entry memory has one read and one write port and moves one entry per cycle.
// Reset (rst, synchronous) empties the list; entry contents are left as they are.
// A stalled result waits in the output register and holds the sequencer.
`default_nettype none

module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire pal_pkg::req_t  req,
  output logic                resp_valid,
  input  wire logic           resp_stall,
  output pal_pkg::resp_t      resp
);

  `include "positional_array_list_assert.svh"

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOVE  = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_TAKE  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state;
  logic [1:0]    op;
  logic [AW-1:0] idx;
  pal_pkg::rec_t rec;
  logic [1:0]    status;
  logic [CW-1:0] count;
  logic [CW-1:0] moves;
  logic [AW-1:0] src;
  logic          mv_valid;
  logic [AW-1:0] mv_dst;
  pal_pkg::rec_t res;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [1:0]    chk_status;
  logic [2:0]    chk_state;
  logic [CW-1:0] chk_moves;
  logic [AW-1:0] chk_src;
  logic [CW-1:0] count_next;
  logic [PW-1:0] len_w;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pal_pkg::rec_t mem_wdata;
  logic          mem_re;
  pal_pkg::rec_t mem_rdata;

  assign req_stall = (state != S_IDLE);
  assign pos_w     = PW'(req.position);
  assign cnt_w     = PW'(count);

  always_comb begin
    chk_status = pal_pkg::ST_RANGE;
    chk_moves  = '0;
    chk_src    = '0;
    case (req.opcode)
      pal_pkg::OP_INSERT: begin
        if (pos_w >= PW'(1) && pos_w <= cnt_w + PW'(1)) begin
          if (count == CW'(CAPACITY)) begin
            chk_status = pal_pkg::ST_FULL;
          end else begin
            chk_status = pal_pkg::ST_DONE;
            chk_moves  = CW'(cnt_w + PW'(1) - pos_w);
            chk_src    = AW'(cnt_w - PW'(1));
          end
        end
      end
      pal_pkg::OP_DELETE: begin
        if (pos_w >= PW'(1) && pos_w <= cnt_w) begin
          chk_status = pal_pkg::ST_DONE;
          chk_moves  = CW'(cnt_w - pos_w);
          chk_src    = AW'(pos_w);
        end
      end
      pal_pkg::OP_READ: begin
        if (pos_w >= PW'(1) && pos_w <= cnt_w) begin
          chk_status = pal_pkg::ST_DONE;
          chk_src    = AW'(pos_w - PW'(1));
        end
      end
      default: begin
        chk_status = pal_pkg::ST_RANGE;
      end
    endcase
    if (chk_status != pal_pkg::ST_DONE) begin
      chk_state = S_EMIT;
    end else if (req.opcode == pal_pkg::OP_READ) begin
      chk_state = S_FETCH;
    end else begin
      chk_state = S_MOVE;
    end
  end

  always_comb begin
    count_next = count;
    if (status == pal_pkg::ST_DONE && op == pal_pkg::OP_INSERT) begin
      count_next = count + CW'(1);
    end else if (status == pal_pkg::ST_DONE && op == pal_pkg::OP_DELETE) begin
      count_next = count - CW'(1);
    end
    len_w = PW'(count_next);
  end

  assign mem_we    = (state == S_MOVE && mv_valid) || (state == S_PUT);
  assign mem_waddr = (state == S_PUT) ? idx : mv_dst;
  assign mem_wdata = (state == S_PUT) ? rec : mem_rdata;
  assign mem_re    = (state == S_FETCH) || (state == S_MOVE && moves != '0);

  pal_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (src),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      mv_valid   <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      if (resp_valid && !resp_stall && state != S_EMIT) begin
        resp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op       <= req.opcode;
            idx      <= AW'(pos_w - PW'(1));
            rec      <= '{name_low: req.name_low, name_mid: req.name_mid,
                          name_high: req.name_high, class_value: req.class_value};
            res      <= '0;
            status   <= chk_status;
            moves    <= chk_moves;
            src      <= chk_src;
            mv_valid <= 1'b0;
            state    <= chk_state;
          end
        end
        S_MOVE: begin
          if (moves != '0) begin
            moves    <= moves - CW'(1);
            mv_valid <= 1'b1;
            if (op == pal_pkg::OP_INSERT) begin
              src    <= src - AW'(1);
              mv_dst <= src + AW'(1);
            end else begin
              src    <= src + AW'(1);
              mv_dst <= src - AW'(1);
            end
          end else begin
            mv_valid <= 1'b0;
            if (!mv_valid) begin
              state <= (op == pal_pkg::OP_INSERT) ? S_PUT : S_EMIT;
            end
          end
        end
        S_PUT: begin
          state <= S_EMIT;
        end
        S_FETCH: begin
          state <= S_TAKE;
        end
        S_TAKE: begin
          res   <= mem_rdata;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!resp_valid || !resp_stall) begin
            resp_valid          <= 1'b1;
            resp.status         <= status;
            resp.list_length    <= len_w[6:0];
            resp.read_name_low  <= res.name_low;
            resp.read_name_mid  <= res.name_mid;
            resp.read_name_high <= res.name_high;
            resp.read_class     <= res.class_value;
            count               <= count_next;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PAL_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `PAL_ASSERT(a_count_at_emit, !$stable(count) |-> $past(state == S_EMIT), "stray count change")
  `PAL_ASSERT_ALWAYS(a_move_in_shift, mv_valid |-> state == S_MOVE, "move outside shift")

endmodule

`default_nettype wire

/* design/pal_mem.sv */
`default_nettype none

module pal_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pal_pkg::rec_t wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output pal_pkg::rec_t      rdata
);

  pal_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* tb/positional_array_list_test.sv */
module positional_array_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class list_tracker;
    pal_pkg::rec_t  entries [CAPACITY];
    int             count;
    int             errors;
    pal_pkg::resp_t expected_q [$];

    function void accept_request(pal_pkg::req_t r);
      pal_pkg::resp_t want;
      int pos;
      want = '0;
      want.status = pal_pkg::ST_RANGE;
      pos = r.position;
      case (r.opcode)
        pal_pkg::OP_INSERT: begin
          if (pos >= 1 && pos <= count + 1) begin
            if (count >= CAPACITY) begin
              want.status = pal_pkg::ST_FULL;
            end else begin
              for (int k = count; k >= pos; k--) entries[k] = entries[k - 1];
              entries[pos - 1] = '{r.name_low, r.name_mid, r.name_high, r.class_value};
              count++;
              want.status = pal_pkg::ST_DONE;
            end
          end
        end
        pal_pkg::OP_DELETE: begin
          if (pos >= 1 && pos <= count) begin
            for (int k = pos; k < count; k++) entries[k - 1] = entries[k];
            count--;
            want.status = pal_pkg::ST_DONE;
          end
        end
        pal_pkg::OP_READ: begin
          if (pos >= 1 && pos <= count) begin
            want.read_name_low  = entries[pos - 1].name_low;
            want.read_name_mid  = entries[pos - 1].name_mid;
            want.read_name_high = entries[pos - 1].name_high;
            want.read_class     = entries[pos - 1].class_value;
            want.status = pal_pkg::ST_DONE;
          end
        end
        default: ;
      endcase
      want.list_length = count[6:0];
      expected_q.push_back(want);
    endfunction

    task report(string what);
      errors++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_response(pal_pkg::resp_t got);
      pal_pkg::resp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transfer %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.list_length !== want.list_length)
        report($sformatf("list_length got %0d want %0d", got.list_length, want.list_length));
      if (got.read_name_low !== want.read_name_low)
        report($sformatf("read_name_low got %h want %h", got.read_name_low,
                         want.read_name_low));
      if (got.read_name_mid !== want.read_name_mid)
        report($sformatf("read_name_mid got %h want %h", got.read_name_mid,
                         want.read_name_mid));
      if (got.read_name_high !== want.read_name_high)
        report($sformatf("read_name_high got %h want %h", got.read_name_high,
                         want.read_name_high));
      if (got.read_class !== want.read_class)
        report($sformatf("read_class got %0d want %0d", got.read_class, want.read_class));
    endtask
  endclass

  logic           clk;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  pal_pkg::req_t  req = '0;
  logic           resp_valid;
  logic           resp_stall = 1'b0;
  pal_pkg::resp_t resp;

  int          idle_pct = 23;
  list_tracker tracker = new;

  positional_array_list dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic pal_pkg::req_t make_request(logic [1:0] op, int pos, int kind);
    pal_pkg::req_t r;
    r.opcode = op;
    r.position = pos[6:0];
    r.name_low = {$urandom, $urandom};
    r.name_mid = {$urandom, $urandom};
    r.name_high = $urandom;
    r.class_value = $urandom;
    case (kind)
      0: begin
        r.name_low = '0;
        r.name_mid = '0;
        r.name_high = '0;
        r.class_value = {1'b1, 31'b0};
      end
      1: begin
        r.name_low = '1;
        r.name_mid = '1;
        r.name_high = '1;
        r.class_value = '1;
      end
      2: r.class_value = {1'b0, {31{1'b1}}};
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_position(int limit);
    int roll;
    roll = $urandom_range(9);
    if (limit < 1) return 1;
    if (roll == 0) return 1;
    if (roll == 1) return limit;
    return $urandom_range(limit, 1);
  endfunction

  task automatic send_request(input pal_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.accept_request(r);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && resp_valid && !resp_stall) tracker.check_response(resp);
      resp_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  initial begin
    int mode;
    int roll;
    int ins_w;
    int del_w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(make_request(pal_pkg::OP_READ, 1, 3));
    send_request(make_request(pal_pkg::OP_DELETE, 1, 3));
    send_request(make_request(pal_pkg::OP_INSERT, 0, 3));
    send_request(make_request(pal_pkg::OP_INSERT, 2, 3));
    send_request(make_request(pal_pkg::OP_INSERT, 1, 1));
    send_request(make_request(pal_pkg::OP_INSERT, 1, 0));
    send_request(make_request(pal_pkg::OP_INSERT, 3, 2));
    send_request(make_request(pal_pkg::OP_INSERT, 2, 3));
    for (int p = 1; p <= 5; p++) send_request(make_request(pal_pkg::OP_READ, p, 3));
    send_request(make_request(pal_pkg::OP_READ, 127, 1));
    send_request(make_request(pal_pkg::OP_DELETE, 0, 3));
    send_request(make_request(pal_pkg::OP_DELETE, 5, 3));
    send_request(make_request(OP_UNUSED, 1, 3));
    send_request(make_request(pal_pkg::OP_DELETE, 4, 3));
    send_request(make_request(pal_pkg::OP_DELETE, 1, 3));
    send_request(make_request(pal_pkg::OP_READ, 1, 3));
    send_request(make_request(pal_pkg::OP_READ, 2, 3));
    send_request(make_request(pal_pkg::OP_INSERT, 3, 1));
    send_request(make_request(pal_pkg::OP_READ, 3, 3));

    for (int n = 0; n < 1300; n++) begin
      idle_pct = (n >= 500 && n < 800) ? 0 : 23;
      mode = (n / 100) % 4;
      case (mode)
        0: begin ins_w = 65; del_w = 10; end
        2: begin ins_w = 10; del_w = 65; end
        default: begin ins_w = 35; del_w = 35; end
      endcase
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_request(make_request(2'($urandom_range(3)), $urandom_range(127),
                                  $urandom_range(15)));
      end else begin
        roll = $urandom_range(99);
        if (roll < ins_w)
          send_request(make_request(pal_pkg::OP_INSERT, pick_position(tracker.count + 1),
                                    $urandom_range(15)));
        else if (roll < ins_w + del_w)
          send_request(make_request(pal_pkg::OP_DELETE, pick_position(tracker.count),
                                    $urandom_range(15)));
        else
          send_request(make_request(pal_pkg::OP_READ, pick_position(tracker.count),
                                    $urandom_range(15)));
      end
    end

    req_valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* positional_array_list.f */
+incdir+design
design/pal_pkg.sv
design/pal_mem.sv
design/positional_array_list.sv
tb/positional_array_list_test.sv
